// File: rtl/slwp_pkg.sv
package slwp_pkg;

    localparam int TIME_W = 32;
    localparam int WIN_W  = 26;
    localparam int PCT_W  = 7;

    // window / 100 fits in 20 bits for any 26-bit window
    localparam int QUOT_W = 20;
    localparam int P1_W   = QUOT_W + PCT_W;
    localparam int P2_W   = 2 * PCT_W;

    localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MAX      = 7'd127;

    localparam int WINDOW_RESET_MS = 1 * 60 * 1000;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = WIN_W'(WINDOW_RESET_MS);
    localparam logic [QUOT_W-1:0] QUOT_RESET   = QUOT_W'(WINDOW_RESET_MS / 100);
    localparam logic [PCT_W-1:0]  REM_RESET    = PCT_W'(WINDOW_RESET_MS % 100);

    // ceil(2^32 / 100): exact floor(w / 100) for any w below 2^30
    localparam logic [WIN_W-1:0] RECIP_100   = 26'd42949673;
    localparam int               RECIP_SHIFT = 32;

    // ceil(2^19 / 100): exact floor(x / 100) for x below 99 * 99 + 1
    localparam int               SMALL_W     = 13;
    localparam logic [SMALL_W-1:0] RECIP_SMALL = 13'd5243;
    localparam int               SMALL_SHIFT = 19;
    localparam int               SMALL_PROD_W = P2_W + SMALL_W;
    localparam int               DIV_W       = SMALL_PROD_W - SMALL_SHIFT;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_WAIT  = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [WIN_W-1:0]  window;
        logic [QUOT_W-1:0] quot;
        logic [PCT_W-1:0]  rem;
    } t_win_cfg;

endpackage

// File: rtl/slwp_cfg.sv
module slwp_cfg import slwp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_data,
    output t_win_cfg         o_cfg
);

    logic [2*WIN_W-1:0] w_prod;
    logic [QUOT_W-1:0]  w_quot;
    logic [WIN_W-1:0]   w_quot_x100;
    logic [WIN_W-1:0]   w_rem_full;

    t_win_cfg r_cfg;

    // split the window into window/100 and window%100 at write time
    assign w_prod      = {{WIN_W{1'b0}}, i_cfg_data} * {{WIN_W{1'b0}}, RECIP_100};
    assign w_quot      = w_prod[RECIP_SHIFT +: QUOT_W];
    assign w_quot_x100 = {{(WIN_W-QUOT_W){1'b0}}, w_quot}
                         * {{(WIN_W-PCT_W){1'b0}}, FULL_PERCENT};
    assign w_rem_full  = i_cfg_data - w_quot_x100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window <= WINDOW_RESET;
            r_cfg.quot   <= QUOT_RESET;
            r_cfg.rem    <= REM_RESET;
        end else if (i_cfg_we) begin
            r_cfg.window <= i_cfg_data;
            r_cfg.quot   <= w_quot;
            r_cfg.rem    <= w_rem_full[PCT_W-1:0];
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/slwp_core.sv
module slwp_core import slwp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [TIME_W-1:0] i_time,
    input  logic [PCT_W-1:0]  i_duty,
    input  t_win_cfg          i_cfg,
    output logic              o_level
);

    t_phase r_phase;
    t_phase n_phase;
    t_phase w_eff_phase;

    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_end_m1;
    logic [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]   r_p2;

    logic [PCT_W-1:0]        w_k;
    logic [P1_W-1:0]         w_p1;
    logic [P2_W-1:0]         w_p2;
    logic [SMALL_PROD_W-1:0] w_small;
    logic [DIV_W-1:0]        w_div;
    logic [TIME_W-1:0]       w_switch;
    logic [TIME_W-1:0]       w_end_m1;
    logic                    w_duty_full;
    logic                    w_duty_zero;

    // time at or before the window start restarts the window
    always_comb begin
        if (r_phase != PH_START && i_time <= r_start) begin
            w_eff_phase = PH_START;
        end else begin
            w_eff_phase = r_phase;
        end
    end

    assign w_k  = FULL_PERCENT - i_duty;
    assign w_p1 = {{(P1_W-QUOT_W){1'b0}}, i_cfg.quot} * {{(P1_W-PCT_W){1'b0}}, w_k};
    assign w_p2 = {{(P2_W-PCT_W){1'b0}}, i_cfg.rem} * {{(P2_W-PCT_W){1'b0}}, w_k};

    // off time = quot*k + floor(rem*k / 100), folded onto the start time
    assign w_small  = {{SMALL_W{1'b0}}, r_p2} * {{P2_W{1'b0}}, RECIP_SMALL};
    assign w_div    = w_small[SMALL_SHIFT +: DIV_W];
    assign w_switch = r_start + {{(TIME_W-P1_W){1'b0}}, r_p1}
                      + {{(TIME_W-DIV_W){1'b0}}, w_div};
    assign w_end_m1 = i_time + {{(TIME_W-WIN_W){1'b0}}, i_cfg.window} - TIME_W'(1);

    assign w_duty_zero = (i_duty == '0);

    always_comb begin
        w_duty_full = i_duty inside {[FULL_PERCENT:PCT_MAX]};
    end

    always_comb begin
        n_phase = w_eff_phase;
        case (w_eff_phase)
            PH_START: begin
                if (w_duty_zero) begin
                    n_phase = PH_LOW;
                end else if (w_duty_full) begin
                    n_phase = PH_HIGH;
                end else begin
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (i_time >= w_switch) begin
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH, PH_LOW: begin
                if (i_time >= r_end_m1) begin
                    n_phase = PH_START;
                end
            end
            default: n_phase = PH_START;
        endcase
    end

    always_comb begin
        case (w_eff_phase)
            PH_START: o_level = w_duty_full;
            PH_WAIT:  o_level = (i_time >= w_switch);
            PH_HIGH:  o_level = 1'b1;
            PH_LOW:   o_level = 1'b0;
            default:  o_level = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_eff_phase == PH_START) begin
            r_start  <= i_time;
            r_end_m1 <= w_end_m1;
            r_p1     <= w_p1;
            r_p2     <= w_p2;
        end
    end

endmodule

// File: rtl/slow_window_pwm_top.sv
// A transfer accepted into the input register moves on to the output register.
// Throughput: one item per cycle while the output register is not stalled; the window
// state updates in the single pass from the input register to the output register.
// Reset (i_rst_n low, synchronous): both stages empty, phase back to window start,
// window register back to 60000 ms.
module slow_window_pwm_top import slwp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WIN_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [TIME_W-1:0] i_time_ms,
    input  logic [PCT_W-1:0]  i_duty_percent,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_drive_high
);

    t_win_cfg w_cfg;

    // input stage
    logic              r_s1_valid;
    logic [TIME_W-1:0] r_s1_time;
    logic [PCT_W-1:0]  r_s1_duty;

    // output stage
    logic r_out_valid;
    logic r_out_drive;

    logic w_out_ready;
    logic w_adv;
    logic w_take;
    logic w_level;

    // the output register frees up when empty or when its transfer completes
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_adv       = r_s1_valid && w_out_ready;
    assign o_stall     = r_s1_valid && !w_out_ready;
    assign w_take      = i_valid && !o_stall;

    slwp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // window state advances only when the item moves into the output register
    slwp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_time  (r_s1_time),
        .i_duty  (r_s1_duty),
        .i_cfg   (w_cfg),
        .o_level (w_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // hold the item while it waits for the output register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_time <= i_time_ms;
            r_s1_duty <= i_duty_percent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_drive <= w_level;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_drive_high = r_out_drive;

endmodule

// File: rtl/slwp_chk.sv
module slwp_chk import slwp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [WIN_W-1:0]  i_cfg_data,
    input logic              i_valid,
    input logic              o_stall,
    input logic [TIME_W-1:0] i_time_ms,
    input logic [PCT_W-1:0]  i_duty_percent,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_drive_high
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive_high))
        else $error("stalled result changed");

    // input side backs up only behind a stalled, full output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // an accepted transfer reaches the output when the next cycle is not stalled
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted transfer did not reach the output");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind slow_window_pwm_top slwp_chk u_slwp_chk (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import slwp_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [PCT_W-1:0]  duty;
        logic              drive;
    } t_drive_rec;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [WIN_W-1:0]  i_cfg_data     = '0;
    logic              i_valid        = 1'b0;
    logic [TIME_W-1:0] i_time_ms      = '0;
    logic [PCT_W-1:0]  i_duty_percent = '0;
    logic              i_stall        = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_drive_high;

    // window model state, kept in step with every accepted transfer
    logic [WIN_W-1:0]  win_ms;
    t_phase            pwm_phase;
    logic [TIME_W-1:0] pwm_start;
    logic [TIME_W-1:0] pwm_switch_on;
    logic [TIME_W-1:0] pwm_end;

    t_drive_rec drive_expect_q[$];
    int         fail_count     = 0;
    int         rx_hold_cycles = 0;
    bit         tx_quiet       = 1'b0;
    bit         rx_quiet       = 1'b0;

    slow_window_pwm_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_time_ms      (i_time_ms),
        .i_duty_percent (i_duty_percent),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive_high   (o_drive_high)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void clear_window_state();
        pwm_phase     = PH_START;
        pwm_start     = '0;
        pwm_switch_on = '0;
        pwm_end       = '0;
    endfunction

    // Advance the window model by one time sample and return the drive level.
    // Compares are plain unsigned ones; sums wrap at 32 bits.
    function automatic logic predict_drive(input logic [TIME_W-1:0] t,
                                           input logic [PCT_W-1:0] duty);
        logic [63:0]      off_ms;
        logic [PCT_W-1:0] off_pct;
        logic             lvl;
        lvl = 1'b0;
        // time went back to or before the window start: restart at once
        if (pwm_phase != PH_START && t <= pwm_start)
            clear_window_state();
        case (pwm_phase)
            PH_START: begin
                pwm_start = t;
                pwm_end   = t + TIME_W'(win_ms);
                if (duty == '0) begin
                    pwm_phase = PH_LOW;
                end else if (duty >= FULL_PERCENT) begin
                    pwm_phase = PH_HIGH;
                    lvl       = 1'b1;
                end else begin
                    // full-width product, quotient truncated to the time width
                    off_pct       = FULL_PERCENT - duty;
                    off_ms        = (64'(win_ms) * 64'(off_pct)) / 64'(FULL_PERCENT);
                    pwm_phase     = PH_WAIT;
                    pwm_switch_on = t + off_ms[TIME_W-1:0];
                end
            end
            PH_WAIT: begin
                if (t >= pwm_switch_on) begin
                    pwm_phase = PH_HIGH;
                    lvl       = 1'b1;
                end
            end
            PH_HIGH: begin
                if (t >= pwm_end - 32'd1)
                    pwm_phase = PH_START;
                lvl = 1'b1;
            end
            default: begin
                if (t >= pwm_end - 32'd1)
                    pwm_phase = PH_START;
            end
        endcase
        return lvl;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PCT_W-1:0] pick_duty();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 22)
            return PCT_W'($urandom_range(100, 127));
        return PCT_W'($urandom_range(1, 99));
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Offer one sample, hold it until the transfer, then record the expected
    // drive level and idle for a random gap.
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [PCT_W-1:0] duty);
        t_drive_rec rec;
        int         gap;
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_time_ms      <= t;
        i_duty_percent <= duty;
        do
            @(posedge i_clk);
        while (o_stall);
        rec.t     = t;
        rec.duty  = duty;
        rec.drive = predict_drive(t, duty);
        drive_expect_q.push_back(rec);
        gap = tx_quiet ? 0 : pick_idle_cycles();
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected level has come out.
    task automatic settle_outputs();
        @(negedge i_clk) i_valid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Only call with the block idle; the model picks up the new length at
    // the same edge as the register.
    task automatic write_window(input logic [WIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        win_ms = value;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Reset length of 60000 ms: switch-on and end boundaries, time going
    // back, equal start time, duty above 100, and windows across the wrap.
    task automatic test_default_window();
        send_sample(32'd100, 7'd50);
        send_sample(pwm_switch_on - 32'd1, 7'd50);
        send_sample(pwm_switch_on, 7'd50);
        send_sample(pwm_end - 32'd2, 7'd50);
        send_sample(pwm_end - 32'd1, 7'd0);
        send_sample(pwm_end, 7'd0);
        send_sample(32'd50, 7'd127);
        send_sample(32'd50, 7'd1);
        send_sample(pwm_switch_on, 7'd1);
        send_sample(32'hFFFF_FFF0, 7'd99);
        send_sample(32'hFFFF_FFF8, 7'd101);
        send_sample(32'hFFFF_FFFF, 7'd1);
        send_sample(32'd5, 7'd50);
    endtask

    // Shortest, zero and largest window lengths, plus a 40000000 ms window.
    task automatic test_window_extremes();
        settle_outputs();
        write_window(WIN_W'(1));
        send_sample(32'd1000, 7'd50);
        send_sample(32'd1001, 7'd50);
        send_sample(32'd1002, 7'd0);
        settle_outputs();
        // zero window: end compare wraps below the start time
        write_window('0);
        send_sample(32'd2000, 7'd0);
        send_sample(32'd2001, 7'd0);
        send_sample(32'd2002, 7'd30);
        settle_outputs();
        write_window('1);
        send_sample(32'd3000, 7'd1);
        send_sample(pwm_switch_on - 32'd1, 7'd1);
        send_sample(pwm_switch_on, 7'd1);
        settle_outputs();
        write_window(WIN_W'(40000000));
        send_sample(32'd100, 7'd99);
        send_sample(pwm_switch_on, 7'd99);
    endtask

    // A new length written inside a running window only applies at the
    // next window start.
    task automatic test_mid_window_write();
        settle_outputs();
        write_window(WIN_W'(1000));
        send_sample(32'd500000, 7'd50);
        settle_outputs();
        write_window(WIN_W'(20));
        send_sample(pwm_switch_on, 7'd50);
        send_sample(pwm_end - 32'd1, 7'd0);
        send_sample(pwm_end, 7'd50);
        send_sample(pwm_switch_on, 7'd50);
    endtask

    // Hold the output side off for a long stretch while samples keep coming
    // back to back, so the block fills and stalls its input.
    task automatic test_output_holdoff();
        logic [TIME_W-1:0] t_now;
        int                k;
        settle_outputs();
        write_window(WIN_W'(200));
        tx_quiet       = 1'b1;
        rx_hold_cycles = 300;
        t_now          = $urandom();
        for (k = 0; k < 40; k++) begin
            t_now = t_now + $urandom_range(0, 30);
            send_sample(t_now, pick_duty());
        end
        settle_outputs();
        tx_quiet = 1'b0;
    endtask

    // Random window sequences: rising time with steps scaled to the window so
    // that windows run to the end, plus jumps back, wrap starts and noise.
    task automatic test_random_windows(input int n_items);
        logic [TIME_W-1:0] t_now;
        logic [TIME_W-1:0] step_max;
        logic [PCT_W-1:0]  duty;
        int                sent;
        int                seq_len;
        int                pick;
        int                k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(2) == 0) begin
                settle_outputs();
                pick = $urandom_range(99);
                if (pick < 60)
                    write_window(WIN_W'($urandom_range(1, 400)));
                else if (pick < 68)
                    write_window('0);
                else if (pick < 76)
                    write_window('1);
                else if (pick < 84)
                    write_window(WIN_W'(40000000));
                else
                    write_window(WIN_W'($urandom_range(401, 2000000)));
            end
            tx_quiet = ($urandom_range(4) == 0);
            rx_quiet = ($urandom_range(4) == 0);
            seq_len  = $urandom_range(4, 40);
            duty     = pick_duty();
            step_max = TIME_W'(win_ms) / 32'd8 + 32'd2;
            if ($urandom_range(9) == 0)
                t_now = 32'hFFFF_FFFF - $urandom_range(0, 3 * int'(win_ms) + 4);
            else
                t_now = $urandom();
            for (k = 0; k < seq_len && sent < n_items; k++) begin
                pick = $urandom_range(99);
                if (pick < 6) begin
                    send_sample($urandom(), PCT_W'($urandom_range(127)));
                end else if (pick < 11) begin
                    // jump back to or just before the current window start
                    t_now = pwm_start - $urandom_range(0, 2);
                    send_sample(t_now, pick_duty());
                end else begin
                    if ($urandom_range(5) == 0)
                        duty = pick_duty();
                    t_now = t_now + $urandom_range(0, step_max);
                    send_sample(t_now, duty);
                end
                sent++;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Output side: random stall runs, or one long hold-off on request.
    initial begin : rx_side
        int run;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                run            = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_stall <= 1'b1;
                repeat (run - 1) @(negedge i_clk);
            end else begin
                run = rx_quiet ? 0 : pick_idle_cycles();
                if (run == 0) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall <= 1'b1;
                    repeat (run - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Compare every output transfer against the oldest expected level.
    always @(posedge i_clk) begin : drive_check
        t_drive_rec head;
        if (i_rst_n && o_valid && !i_stall) begin
            if (drive_expect_q.size() == 0) begin
                note_failure($sformatf("unexpected output transfer, drive_high=%0b",
                                       o_drive_high));
            end else begin
                head = drive_expect_q.pop_front();
                if (o_drive_high !== head.drive)
                    note_failure($sformatf(
                        "drive_high mismatch: time_ms=%0d duty=%0d expected %0b got %0b",
                        head.t, head.duty, head.drive, o_drive_high));
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        win_ms = WINDOW_RESET;
        clear_window_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_default_window();
        test_window_extremes();
        test_mid_window_write();
        test_output_holdoff();
        test_random_windows(1100);

        settle_outputs();
        // let any stray output transfer show up before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
